>>> sv/frictional_pressure_closure_defines.svh
`ifndef FRICTIONAL_PRESSURE_CLOSURE_DEFINES_SVH
`define FRICTIONAL_PRESSURE_CLOSURE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define FPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define FPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/fpc_pkg.sv
`timescale 1ns / 1ps
package fpc_pkg;

  localparam int LOG_ITER_DEF = 16;
  localparam int ONE_Q12 = 4096;
  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

  localparam logic [3:0] REG_COEF  = 4'd0;
  localparam logic [3:0] REG_LOEXP = 4'd1;
  localparam logic [3:0] REG_UPEXP = 4'd2;
  localparam logic [3:0] REG_FLOOR = 4'd3;

  typedef enum logic [1:0] {MODE_CALC, MODE_ZERO, MODE_SAT} mode_t;

  typedef struct packed {
    logic pz;
    logic pi;
    logic sz;
    logic si;
  } flags_t;

  typedef struct packed {
    logic [5:0]  k;
    logic [31:0] y;
  } norm_t;

  function automatic norm_t norm33(input logic [32:0] v);
    norm_t       r;
    logic [63:0] w;
    r.k = 6'd0;
    for (int i = 0; i < 33; i++) begin
      if (v[i]) r.k = 6'(i);
    end
    w = {31'b0, v} << (6'd32 - r.k);
    r.y = w[32:1];
    return r;
  endfunction

  // root of 2 taken idx times, Q1.31
  function automatic logic [63:0] exp_root(input int unsigned idx);
    logic [63:0] c;
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bw;
    c = 64'h1_0000_0000;
    for (int unsigned i = 0; i < idx; i++) begin
      v = c << 31;
      res = 64'd0;
      bw = 64'h4000_0000_0000_0000;
      for (int b = 0; b < 32; b++) begin
        if (v >= res + bw) begin
          v = v - (res + bw);
          res = (res >> 1) + bw;
        end else begin
          res = res >> 1;
        end
        bw = bw >> 2;
      end
      c = res;
    end
    return c;
  endfunction

endpackage

>>> sv/frictional_pressure_closure.sv
`timescale 1ns / 1ps
// Frictional pressure closure, one cell per item.
// Input channel: in_valid/in_stall with solid, onset and packing fractions (Q0.16).
// Output channel: out_valid/out_stall with pressure and slope (Q32.16) and a
// saturation flag.
// Config channel: cfg_valid/cfg_ready (always ready), cfg_index selects
// coefficient, lower exponent, upper exponent or gap floor; other indexes are
// dropped. Write only while the pipeline is empty.
// Stages in order: capture, slope numerator, log2, exponent products, log sums,
// exp2, output register. Throughput: one item per cycle while no result waits
// under out_stall; each log2 and exp2 iteration is one pipeline stage with its
// own multipliers. Reset: config registers take their defaults, all stages empty.
// Stall: when a result waits under out_stall the whole pipeline holds and
// in_stall rises; nothing is dropped or repeated.
module frictional_pressure_closure
  import fpc_pkg::*;
#(
  parameter int LOG_ITERATIONS = LOG_ITER_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_solid_fraction,
  input  logic [15:0] in_friction_onset_fraction,
  input  logic [15:0] in_packing_limit_fraction,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [47:0] out_friction_pressure,
  output logic [47:0] out_pressure_slope,
  output logic        out_saturated,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int L   = LOG_ITERATIONS;
  localparam int FS  = L + 12;
  localparam int LGW = L + 6;
  localparam int DW  = LGW + 1;
  localparam int PW  = 18;
  localparam int MW  = PW + DW;
  localparam int TW  = L + 27;
  localparam logic [LGW-1:0] K16 = LGW'(16) << L;
  localparam logic [LGW-1:0] K28 = LGW'(28) << L;
  localparam logic signed [TW-1:0] T48 = TW'(48) << FS;

  logic [31:0] coef_r;
  logic [15:0] eta_r, p_r, floor_r;
  logic        adv;

  assign cfg_ready = 1'b1;
  assign adv = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r  <= 32'd3277;
      eta_r   <= 16'd8192;
      p_r     <= 16'd20480;
      floor_r <= 16'd3277;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_COEF:  coef_r  <= cfg_data;
        REG_LOEXP: eta_r   <= cfg_data[15:0];
        REG_UPEXP: p_r     <= cfg_data[15:0];
        REG_FLOOR: floor_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // capture: lo and hi
  logic        v0_r;
  logic [15:0] lo0_r, hi0_r, lo_nxt, hi_nxt;

  always_comb begin
    lo_nxt = (in_solid_fraction > in_friction_onset_fraction) ?
             in_solid_fraction - in_friction_onset_fraction : 16'd0;
    hi_nxt = floor_r;
    if (in_packing_limit_fraction > in_solid_fraction &&
        in_packing_limit_fraction - in_solid_fraction > floor_r)
      hi_nxt = in_packing_limit_fraction - in_solid_fraction;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (adv) v0_r <= in_valid;
    if (adv) begin
      lo0_r <= lo_nxt;
      hi0_r <= hi_nxt;
    end
  end

  // slope numerator and special cases
  logic        v1_r;
  logic [15:0] lo1_r, hi1_r;
  logic [32:0] s1_r, s_nxt;
  flags_t      fl1_r, fl_nxt;
  logic [31:0] eh_w, pl_w;

  always_comb begin
    eh_w = eta_r * hi0_r;
    pl_w = p_r * lo0_r;
    s_nxt = {1'b0, eh_w} + {1'b0, pl_w};
    fl_nxt.pz = (coef_r == 32'd0) || (lo0_r == 16'd0 && eta_r != 16'd0);
    fl_nxt.pi = (hi0_r == 16'd0) && (p_r != 16'd0);
    fl_nxt.sz = (coef_r == 32'd0) || (s_nxt == 33'd0) ||
                (lo0_r == 16'd0 && eta_r > 16'(ONE_Q12));
    fl_nxt.si = (hi0_r == 16'd0) || (lo0_r == 16'd0 && eta_r < 16'(ONE_Q12));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= v0_r;
    if (adv) begin
      lo1_r <= lo0_r;
      hi1_r <= hi0_r;
      s1_r  <= s_nxt;
      fl1_r <= fl_nxt;
    end
  end

  // log2 pipeline: stage 0 normalized, then one squaring per stage
  // operands: 0 coefficient, 1 lo, 2 hi, 3 slope numerator
  logic         lv_r  [0:L];
  logic [31:0]  ly_r  [0:L][0:3];
  logic [5:0]   lk_r  [0:L][0:3];
  logic [L-1:0] lf_r  [0:L][0:3];
  flags_t       lfl_r [0:L];
  logic [31:0]  ly_nxt [0:L-1][0:3];
  logic [L-1:0] lf_nxt [0:L-1][0:3];
  norm_t        nm_w [0:3];
  logic [32:0]  nin_w [0:3];

  assign nin_w[0] = {1'b0, coef_r};
  assign nin_w[1] = {17'b0, lo1_r};
  assign nin_w[2] = {17'b0, hi1_r};
  assign nin_w[3] = s1_r;

  always_comb begin
    for (int o = 0; o < 4; o++) nm_w[o] = norm33(nin_w[o]);
  end

  always_comb begin
    logic [63:0] sq;
    for (int j = 0; j < L; j++) begin
      for (int o = 0; o < 4; o++) begin
        sq = ly_r[j][o] * ly_r[j][o];
        if (sq[63]) begin
          ly_nxt[j][o] = sq[63:32];
          lf_nxt[j][o] = {lf_r[j][o][L-2:0], 1'b1};
        end else begin
          ly_nxt[j][o] = sq[62:31];
          lf_nxt[j][o] = {lf_r[j][o][L-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= L; j++) lv_r[j] <= 1'b0;
    end else if (adv) begin
      lv_r[0] <= v1_r;
      for (int j = 0; j < L; j++) lv_r[j+1] <= lv_r[j];
    end
    if (adv) begin
      lfl_r[0] <= fl1_r;
      for (int o = 0; o < 4; o++) begin
        ly_r[0][o] <= nm_w[o].y;
        lk_r[0][o] <= nm_w[o].k;
        lf_r[0][o] <= '0;
      end
      for (int j = 0; j < L; j++) begin
        lfl_r[j+1] <= lfl_r[j];
        for (int o = 0; o < 4; o++) begin
          ly_r[j+1][o] <= ly_nxt[j][o];
          lk_r[j+1][o] <= lk_r[j][o];
          lf_r[j+1][o] <= lf_nxt[j][o];
        end
      end
    end
  end

  // exponent products
  logic [LGW-1:0]         lg_f, lg_l, lg_h, lg_s;
  logic signed [DW-1:0]   dl_w, dh_w;
  logic signed [PW-1:0]   eta_s, e1_s, p_s, p1_s;
  logic signed [MW-1:0]   pe_nxt, pp_nxt, se_nxt, sp_nxt;
  logic signed [LGW+1:0]  bsum_w;
  logic                   xv_r;
  logic signed [TW-1:0]   bp_r, bs_r;
  logic signed [MW-1:0]   pe_r, pp_r, se_r, sp_r;
  flags_t                 xfl_r;

  always_comb begin
    lg_f = {lk_r[L][0], lf_r[L][0]};
    lg_l = {lk_r[L][1], lf_r[L][1]};
    lg_h = {lk_r[L][2], lf_r[L][2]};
    lg_s = {lk_r[L][3], lf_r[L][3]};
    dl_w = $signed({1'b0, lg_l}) - $signed({1'b0, K16});
    dh_w = $signed({1'b0, lg_h}) - $signed({1'b0, K16});
    eta_s = $signed({2'b0, eta_r});
    p_s   = $signed({2'b0, p_r});
    e1_s  = eta_s - PW'(ONE_Q12);
    p1_s  = p_s + PW'(ONE_Q12);
    pe_nxt = eta_s * dl_w;
    pp_nxt = p_s * dh_w;
    se_nxt = e1_s * dl_w;
    sp_nxt = p1_s * dh_w;
    bsum_w = $signed({2'b0, lg_f}) + $signed({2'b0, lg_s}) - $signed({2'b0, K28});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) xv_r <= 1'b0;
    else if (adv) xv_r <= lv_r[L];
    if (adv) begin
      bp_r  <= $signed({{(TW-LGW-12){1'b0}}, lg_f, 12'b0});
      bs_r  <= TW'(bsum_w) <<< 12;
      pe_r  <= pe_nxt;
      pp_r  <= pp_nxt;
      se_r  <= se_nxt;
      sp_r  <= sp_nxt;
      xfl_r <= lfl_r[L];
    end
  end

  // log2 of each raw result
  logic                 tv_r;
  logic signed [TW-1:0] tp_r, ts_r;
  flags_t               tfl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) tv_r <= 1'b0;
    else if (adv) tv_r <= xv_r;
    if (adv) begin
      tp_r  <= bp_r + TW'(pe_r) - TW'(pp_r);
      ts_r  <= bs_r + TW'(se_r) - TW'(sp_r);
      tfl_r <= xfl_r;
    end
  end

  // exp2 pipeline: stage 0 classified, then one root factor per stage
  logic         ev_r [0:L];
  logic [31:0]  ey_r [0:L][0:1];
  logic [L-1:0] ef_r [0:L][0:1];
  logic [5:0]   en_r [0:L][0:1];
  mode_t        em_r [0:L][0:1];
  logic [31:0]  ey_nxt [0:L-1][0:1];
  logic [31:0]  root_w [0:L-1];
  mode_t        mp_nxt, ms_nxt;

  for (genvar j = 0; j < L; j++) begin : g_root
    localparam logic [63:0] RT = exp_root(j + 1);
    assign root_w[j] = RT[31:0];
  end

  always_comb begin
    if (tfl_r.pz) mp_nxt = MODE_ZERO;
    else if (tfl_r.pi) mp_nxt = MODE_SAT;
    else if (tp_r[TW-1]) mp_nxt = MODE_ZERO;
    else if (tp_r >= T48) mp_nxt = MODE_SAT;
    else mp_nxt = MODE_CALC;
    if (tfl_r.sz) ms_nxt = MODE_ZERO;
    else if (tfl_r.si) ms_nxt = MODE_SAT;
    else if (ts_r[TW-1]) ms_nxt = MODE_ZERO;
    else if (ts_r >= T48) ms_nxt = MODE_SAT;
    else ms_nxt = MODE_CALC;
  end

  always_comb begin
    logic [63:0] pr;
    for (int j = 0; j < L; j++) begin
      for (int o = 0; o < 2; o++) begin
        pr = ey_r[j][o] * root_w[j];
        ey_nxt[j][o] = ef_r[j][o][L-1-j] ? pr[62:31] : ey_r[j][o];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= L; j++) ev_r[j] <= 1'b0;
    end else if (adv) begin
      ev_r[0] <= tv_r;
      for (int j = 0; j < L; j++) ev_r[j+1] <= ev_r[j];
    end
    if (adv) begin
      ey_r[0][0] <= 32'h8000_0000;
      ey_r[0][1] <= 32'h8000_0000;
      ef_r[0][0] <= tp_r[FS-1 -: L];
      ef_r[0][1] <= ts_r[FS-1 -: L];
      en_r[0][0] <= tp_r[FS+5:FS];
      en_r[0][1] <= ts_r[FS+5:FS];
      em_r[0][0] <= mp_nxt;
      em_r[0][1] <= ms_nxt;
      for (int j = 0; j < L; j++) begin
        for (int o = 0; o < 2; o++) begin
          ey_r[j+1][o] <= ey_nxt[j][o];
          ef_r[j+1][o] <= ef_r[j][o];
          en_r[j+1][o] <= en_r[j][o];
          em_r[j+1][o] <= em_r[j][o];
        end
      end
    end
  end

  // scale and output register
  logic        out_valid_r, out_sat_r;
  logic [47:0] out_pres_r, out_slope_r;
  logic [47:0] res_nxt [0:1];

  always_comb begin
    logic [78:0] sh;
    for (int o = 0; o < 2; o++) begin
      sh = {47'b0, ey_r[L][o]} << en_r[L][o];
      unique case (em_r[L][o])
        MODE_ZERO: res_nxt[o] = 48'd0;
        MODE_SAT:  res_nxt[o] = MAX48;
        default:   res_nxt[o] = sh[78:31];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= ev_r[L];
    if (adv) begin
      out_pres_r  <= res_nxt[0];
      out_slope_r <= res_nxt[1];
      out_sat_r   <= (em_r[L][0] == MODE_SAT) || (em_r[L][1] == MODE_SAT);
    end
  end

  assign out_valid             = out_valid_r;
  assign out_friction_pressure = out_pres_r;
  assign out_pressure_slope    = out_slope_r;
  assign out_saturated         = out_sat_r;

`include "frictional_pressure_closure_defines.svh"

  `FPC_ASSERT_NOW(a_sat_value, out_valid && out_saturated, out_friction_pressure == MAX48 || out_pressure_slope == MAX48, "saturation flag without clipped value")
  `FPC_ASSERT_NEXT(a_hold_out, out_valid && out_stall, out_valid, "stalled result dropped")
  `FPC_ASSERT_NEXT(a_capture, in_valid && !in_stall, v0_r, "accepted item not captured")

endmodule

>>> test/tb_frictional_pressure_closure.sv
`timescale 1ns / 1ps
module tb_frictional_pressure_closure;
  import fpc_pkg::*;

  localparam int LATENCY = 2 * LOG_ITER_DEF + 7;
  localparam int FRAC_SUM = LOG_ITER_DEF + 12;
  localparam longint CYCLE_LIMIT = 1000000;

  typedef struct {
    logic [47:0] pres;
    logic [47:0] slope;
    logic        sat;
  } cell_result_t;

  class closure_scoreboard;
    logic [31:0] coef = 32'd3277;
    logic [15:0] eta_q = 16'd8192;
    logic [15:0] p_q = 16'd20480;
    logic [15:0] floor_q = 16'd3277;
    cell_result_t pending[$];
    int errors = 0;

    function void set_reg(logic [3:0] idx, logic [31:0] data);
      case (idx)
        REG_COEF:  coef = data;
        REG_LOEXP: eta_q = data[15:0];
        REG_UPEXP: p_q = data[15:0];
        REG_FLOOR: floor_q = data[15:0];
        default: ;
      endcase
    endfunction

    function longint unsigned isq(longint unsigned v);
      longint unsigned res, bw;
      res = 0;
      bw = 64'h4000_0000_0000_0000;
      while (bw > v) bw >>= 2;
      while (bw != 0) begin
        if (v >= res + bw) begin
          v = v - (res + bw);
          res = (res >> 1) + bw;
        end else begin
          res >>= 1;
        end
        bw >>= 2;
      end
      return res;
    endfunction

    function longint lg2(longint unsigned v);
      int k;
      longint unsigned y, fr;
      k = 0;
      fr = 0;
      while (k < 63 && (v >> (k + 1)) != 0) k++;
      y = (k <= 31) ? (v << (31 - k)) : (v >> (k - 31));
      for (int i = 0; i < LOG_ITER_DEF; i++) begin
        y = (y * y) >> 31;
        fr <<= 1;
        if (y >= 64'h1_0000_0000) begin
          y >>= 1;
          fr |= 1;
        end
      end
      return (longint'(k) << LOG_ITER_DEF) + longint'(fr);
    endfunction

    function longint unsigned pow2(longint t, ref bit sat);
      longint unsigned y, c;
      longint n;
      y = 64'h8000_0000;
      c = 64'h1_0000_0000;
      if (t < 0) return 0;
      if (t >= (longint'(48) << FRAC_SUM)) begin
        sat = 1;
        return 64'(MAX48);
      end
      n = t >>> FRAC_SUM;
      for (int i = 1; i <= LOG_ITER_DEF; i++) begin
        c = isq(c << 31);
        if (((t >>> (FRAC_SUM - i)) & 1) != 0) y = (y * c) >> 31;
      end
      return (n >= 31) ? (y << (n - 31)) : (y >> (31 - n));
    endfunction

    function void note(logic [15:0] a, logic [15:0] amin, logic [15:0] amax);
      longint lo, hi, eta, p, e1, k16, t;
      longint unsigned s, pres, slope;
      bit sat;
      cell_result_t r;
      lo = longint'(a) - longint'(amin);
      hi = longint'(amax) - longint'(a);
      eta = longint'(eta_q);
      p = longint'(p_q);
      e1 = eta - ONE_Q12;
      k16 = longint'(16) << LOG_ITER_DEF;
      sat = 0;
      if (lo < 0) lo = 0;
      if (hi < longint'(floor_q)) hi = longint'(floor_q);
      if (coef == 0 || (lo == 0 && eta > 0)) begin
        pres = 0;
      end else if (hi == 0 && p > 0) begin
        pres = 64'(MAX48);
        sat = 1;
      end else begin
        t = ONE_Q12 * lg2(64'(coef));
        if (eta > 0) t += eta * (lg2(lo) - k16);
        if (p > 0) t -= p * (lg2(hi) - k16);
        pres = pow2(t, sat);
      end
      s = longint'(eta) * hi + longint'(p) * lo;
      if (coef == 0 || s == 0 || (lo == 0 && e1 > 0)) begin
        slope = 0;
      end else if (hi == 0 || (lo == 0 && e1 < 0)) begin
        slope = 64'(MAX48);
        sat = 1;
      end else begin
        t = ONE_Q12 * (lg2(64'(coef)) + lg2(s) - (longint'(28) << LOG_ITER_DEF));
        if (e1 != 0) t += e1 * (lg2(lo) - k16);
        t -= (p + ONE_Q12) * (lg2(hi) - k16);
        slope = pow2(t, sat);
      end
      r.pres = pres[47:0];
      r.slope = slope[47:0];
      r.sat = sat;
      pending.push_back(r);
    endfunction

    function void check(logic [47:0] pres, logic [47:0] slope, logic sat);
      cell_result_t r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected item pres=%h slope=%h sat=%b", $time, pres, slope, sat);
        errors++;
        return;
      end
      r = pending.pop_front();
      if (pres !== r.pres) begin
        $display("%0t: pressure expected %h actual %h", $time, r.pres, pres);
        errors++;
      end
      if (slope !== r.slope) begin
        $display("%0t: slope expected %h actual %h", $time, r.slope, slope);
        errors++;
      end
      if (sat !== r.sat) begin
        $display("%0t: saturated expected %b actual %b", $time, r.sat, sat);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] in_solid_fraction;
  logic [15:0] in_friction_onset_fraction;
  logic [15:0] in_packing_limit_fraction;
  logic        out_valid;
  logic        out_stall;
  logic [47:0] out_friction_pressure;
  logic [47:0] out_pressure_slope;
  logic        out_saturated;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_index;
  logic [31:0] cfg_data;

  closure_scoreboard sb;
  bit long_hold;
  longint cycles;

  frictional_pressure_closure dut (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst_n <= 0;
    in_valid <= 0;
    in_solid_fraction <= 0;
    in_friction_onset_fraction <= 0;
    in_packing_limit_fraction <= 0;
    cfg_valid <= 0;
    cfg_index <= 0;
    cfg_data <= 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("frictional_pressure_closure test failed");
        $finish;
      end
    end
  end

  // receiver
  initial begin
    int gap;
    out_stall <= 0;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold) begin
        out_stall <= 1;
        repeat (300) @(posedge clk);
        long_hold = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        out_stall <= 1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 0;
      do @(posedge clk); while (!out_valid);
      sb.check(out_friction_pressure, out_pressure_slope, out_saturated);
    end
  end

  task automatic send_cell(logic [15:0] a, logic [15:0] amin, logic [15:0] amax,
                           bit busy);
    int gap;
    gap = busy ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_solid_fraction <= a;
    in_friction_onset_fraction <= amin;
    in_packing_limit_fraction <= amax;
    do @(posedge clk); while (in_stall);
    sb.note(a, amin, amax);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [31:0] data);
    in_valid <= 0;
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic random_cells(int count, bit busy);
    logic [15:0] a, amin, amax;
    for (int i = 0; i < count; i++) begin
      a = 16'($urandom);
      if ($urandom_range(0, 3) == 0) begin
        amin = 16'($urandom);
        amax = 16'($urandom);
      end else begin
        amin = a - 16'($urandom_range(0, 20000));
        amax = a + 16'($urandom_range(0, 20000));
        if (amin > a) amin = 0;
        if (amax < a) amax = 16'hFFFF;
      end
      send_cell(a, amin, amax, busy);
    end
  endtask

  task automatic directed_cells();
    send_cell(16'h0000, 16'h0000, 16'h0000, 0);
    send_cell(16'hFFFF, 16'h0000, 16'hFFFF, 0);
    send_cell(16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
    send_cell(16'h0000, 16'hFFFF, 16'hFFFF, 0);
    send_cell(16'h8000, 16'h4000, 16'h8000, 0);
    send_cell(16'h8000, 16'h4000, 16'h2000, 0);
    send_cell(16'hC000, 16'h8000, 16'hF000, 0);
    send_cell(16'h5555, 16'hAAAA, 16'h5555, 0);
  endtask

  initial begin
    sb = new();
    long_hold = 0;
    @(posedge clk iff rst_n);
    @(posedge clk);
    directed_cells();
    random_cells(150, 0);
    long_hold = 1;
    random_cells(120, 1);
    drain();

    write_reg(REG_COEF, 32'd0);
    write_reg(4'd9, 32'h1234_5678);
    directed_cells();
    random_cells(60, 0);
    drain();

    write_reg(REG_COEF, 32'hFFFF_FFFF);
    write_reg(REG_LOEXP, 32'd0);
    write_reg(REG_UPEXP, 32'd0);
    directed_cells();
    random_cells(100, 0);
    drain();

    write_reg(REG_LOEXP, 32'h0000_FFFF);
    write_reg(REG_UPEXP, 32'h0000_FFFF);
    write_reg(REG_FLOOR, 32'd0);
    directed_cells();
    random_cells(150, 0);
    drain();

    write_reg(REG_LOEXP, 32'd4096);
    write_reg(REG_UPEXP, 32'd4096);
    write_reg(REG_FLOOR, 32'h0000_FFFF);
    directed_cells();
    random_cells(100, 0);
    drain();

    write_reg(REG_LOEXP, 32'd2048);
    write_reg(REG_FLOOR, 32'd0);
    write_reg(REG_COEF, 32'd1);
    directed_cells();
    random_cells(100, 0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_COEF, $urandom);
      write_reg(REG_LOEXP, $urandom_range(0, 65535));
      write_reg(REG_UPEXP, $urandom_range(0, 65535));
      write_reg(REG_FLOOR, $urandom_range(0, 65535));
      write_reg(4'($urandom_range(4, 15)), $urandom);
      random_cells(100, 0);
      drain();
    end

    if (sb.errors == 0) begin
      $display("frictional_pressure_closure test passed");
    end else begin
      $display("frictional_pressure_closure test failed");
    end
    $finish;
  end

endmodule
